// ===== rtl/core/mfde_pkg.sv =====
// shared types, constants and address helper for the framebuffer draw engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mfde_pkg;
   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_SIZE   = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W       = $clog2(STORE_SIZE);
   localparam logic [7:0] CHAR_MIN = 8'd32;
   localparam logic [7:0] CHAR_MAX = 8'd126;
   localparam logic [15:0] GLYPH_MSB = 16'h8000;
   localparam logic [7:0] FILL_WHITE = 8'hFF;
   localparam logic [7:0] FILL_BLACK = 8'h00;
   localparam logic [4:0] FONT_HEIGHT_RESET = 5'd8;

   typedef enum logic [2:0] {
      OP_CURSOR = 3'd0,
      OP_FILL   = 3'd1,
      OP_PIXEL  = 3'd2,
      OP_GLYPH  = 3'd3,
      OP_RECT   = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_TOP,
      PH_BOTTOM,
      PH_LEFT,
      PH_RIGHT
   } phase_type;

   function automatic logic [ADDR_W-1:0] store_addr(input logic [8:0] col,
                                                     input logic [8:0] page);
      logic [19:0] a;
      a = 20'(col) + 20'(page) * 20'(PANEL_WIDTH);
      return a[ADDR_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mfde_ram.sv =====
// generic simple dual port ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/mono_framebuffer_draw_engine.sv =====
// a stalled response keeps the engine in its done state until the output register is free
// one request in work at a time; the single ram port pair sets the pace
// reset starts a clearing pass over all STORE_SIZE (1024) bytes before requests are taken
// uses mfde_pkg and mfde_ram
`timescale 1ns / 1ps
`default_nettype none
module mono_framebuffer_draw_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_x,
   input  wire logic [7:0]  req_y,
   input  wire logic        req_color,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [15:0] req_row_bits,
   input  wire logic [3:0]  req_row_index,
   input  wire logic [4:0]  req_glyph_width,
   input  wire logic        req_last_row,
   input  wire logic [7:0]  req_rect_width,
   input  wire logic [7:0]  req_rect_height,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic [7:0]       rsp_read_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_font_height
);
   import mfde_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [7:0]  cc_ff, cc_in, cr_ff, cr_in;
   logic        skip_ff, skip_in;
   logic [4:0]  fh_ff;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [7:0]  fill_ff, fill_in;
   logic        clr_rsp_ff, clr_rsp_in;
   logic        rect_ff, rect_in;
   logic        color_ff, color_in;
   logic [15:0] bits_ff, bits_in;
   logic [7:0]  lim_ff, lim_in, j_ff, j_in, rw_ff, rw_in, rh_ff, rh_in;
   logic [7:0]  bc_ff, bc_in;
   logic [8:0]  br_ff, br_in;
   logic        status_ff, status_in;
   logic [7:0]  data_ff, data_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0]  bit_ff, bit_in;
   logic        pcol_ff, pcol_in;

   logic              we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [7:0]        wdata, rdata;

   logic [8:0] px, py;
   logic [7:0] lim;
   logic       pcol, on, bad;
   logic [8:0] col_sum;

   mfde_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   always_comb begin
      px = 9'(bc_ff) + 9'(j_ff);
      py = br_ff;
      lim = lim_ff;
      if (rect_ff) begin
         case (phase_ff)
            PH_TOP: begin
               lim = rw_ff;
            end
            PH_BOTTOM: begin
               py = br_ff + 9'(rh_ff) - 9'd1;
               lim = rw_ff;
            end
            PH_LEFT: begin
               px = 9'(bc_ff);
               py = br_ff + 9'(j_ff);
               lim = rh_ff;
            end
            default: begin
               px = 9'(bc_ff) + 9'(rw_ff) - 9'd1;
               py = br_ff + 9'(j_ff);
               lim = rh_ff;
            end
         endcase
      end
      on = (j_ff < 8'd16) && ((bits_ff << j_ff[3:0]) & GLYPH_MSB) != 16'd0;
      pcol = rect_ff ? color_ff : (on ? color_ff : ~color_ff);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cc_in = cc_ff;
      cr_in = cr_ff;
      skip_in = skip_ff;
      clr_in = clr_ff;
      fill_in = fill_ff;
      clr_rsp_in = clr_rsp_ff;
      rect_in = rect_ff;
      color_in = color_ff;
      bits_in = bits_ff;
      lim_in = lim_ff;
      j_in = j_ff;
      rw_in = rw_ff;
      rh_in = rh_ff;
      bc_in = bc_ff;
      br_in = br_ff;
      status_in = status_ff;
      data_in = data_ff;
      addr_in = addr_ff;
      bit_in = bit_ff;
      pcol_in = pcol_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      we = 1'b0;
      waddr = clr_ff;
      wdata = fill_ff;
      raddr = addr_ff;
      req_ready = 1'b0;
      bad = 1'b0;
      col_sum = 9'(cc_ff) + 9'(req_glyph_width);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            raddr = store_addr(9'(req_x), 9'(req_y));
            if (req_valid) begin
               status_in = 1'b0;
               data_in = 8'd0;
               j_in = 8'd0;
               phase_in = PH_TOP;
               color_in = req_color;
               state_in = ST_DONE;
               case (req_opcode)
                  OP_CURSOR: begin
                     cc_in = req_x;
                     cr_in = req_y;
                  end
                  OP_FILL: begin
                     fill_in = req_color ? FILL_WHITE : FILL_BLACK;
                     clr_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  OP_PIXEL: begin
                     rect_in = 1'b0;
                     bits_in = GLYPH_MSB;
                     lim_in = 8'd1;
                     bc_in = req_x;
                     br_in = 9'(req_y);
                     state_in = ST_PIX_RD;
                  end
                  OP_GLYPH: begin
                     bad = req_char_code < CHAR_MIN || req_char_code > CHAR_MAX
                        || col_sum > 9'(PANEL_WIDTH)
                        || (9'(cr_ff) + 9'(fh_ff)) > 9'(PANEL_HEIGHT);
                     skip_in = (req_row_index == 4'd0) ? bad : skip_ff;
                     if (skip_in) begin
                        status_in = 1'b1;
                     end else begin
                        if (5'(req_row_index) < fh_ff) begin
                           rect_in = 1'b0;
                           bits_in = req_row_bits;
                           lim_in = 8'(req_glyph_width);
                           bc_in = cc_ff;
                           br_in = 9'(cr_ff) + 9'(req_row_index);
                           state_in = ST_PIX_RD;
                        end
                        if (req_last_row) begin
                           cc_in = col_sum[7:0];
                        end
                     end
                     if (req_last_row) begin
                        skip_in = 1'b0;
                     end
                  end
                  OP_RECT: begin
                     if ((9'(cc_ff) + 9'(req_rect_width)) > 9'(PANEL_WIDTH)
                         || (9'(cr_ff) + 9'(req_rect_height)) > 9'(PANEL_HEIGHT)) begin
                        status_in = 1'b1;
                     end else if (req_rect_width != 8'd0 && req_rect_height != 8'd0) begin
                        rect_in = 1'b1;
                        rw_in = req_rect_width;
                        rh_in = req_rect_height;
                        bc_in = cc_ff;
                        br_in = 9'(cr_ff);
                        state_in = ST_PIX_RD;
                     end
                  end
                  OP_READ: begin
                     if (9'(req_x) >= 9'(PANEL_WIDTH) || 9'(req_y) >= 9'(PAGE_COUNT)) begin
                        status_in = 1'b1;
                     end else begin
                        state_in = ST_READ_WAIT;
                     end
                  end
                  default: begin
                     status_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == STORE_SIZE - 1) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_PIX_RD: begin
            raddr = store_addr(px, 9'(py[8:3]));
            if (j_ff == lim) begin
               j_in = 8'd0;
               if (rect_ff && phase_ff != PH_RIGHT) begin
                  phase_in = phase_type'(phase_ff + 2'd1);
               end else begin
                  state_in = ST_DONE;
               end
            end else if (px < 9'(PANEL_WIDTH) && py < 9'(PANEL_HEIGHT)) begin
               addr_in = raddr;
               bit_in = py[2:0];
               pcol_in = pcol;
               state_in = ST_PIX_WR;
            end else begin
               j_in = j_ff + 8'd1;
            end
         end
         ST_PIX_WR: begin
            we = 1'b1;
            waddr = addr_ff;
            wdata = pcol_ff ? (rdata | (8'd1 << bit_ff)) : (rdata & ~(8'd1 << bit_ff));
            j_in = j_ff + 8'd1;
            state_in = ST_PIX_RD;
         end
         ST_READ_WAIT: begin
            data_in = rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in = data_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         fill_ff <= FILL_BLACK;
         clr_rsp_ff <= 1'b0;
         cc_ff <= 8'd0;
         cr_ff <= 8'd0;
         skip_ff <= 1'b0;
         fh_ff <= FONT_HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fill_ff <= fill_in;
         clr_rsp_ff <= clr_rsp_in;
         cc_ff <= cc_in;
         cr_ff <= cr_in;
         skip_ff <= skip_in;
         if (csr_valid) begin
            fh_ff <= csr_font_height;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff <= phase_in;
      rect_ff <= rect_in;
      color_ff <= color_in;
      bits_ff <= bits_in;
      lim_ff <= lim_in;
      j_ff <= j_in;
      rw_ff <= rw_in;
      rh_ff <= rh_in;
      bc_ff <= bc_in;
      br_ff <= br_in;
      status_ff <= status_in;
      data_ff <= data_in;
      addr_ff <= addr_in;
      bit_ff <= bit_in;
      pcol_ff <= pcol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !we) else $error("ram write while idle");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR) else $error("reset did not start clearing");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE)) else $error("response outside done");
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      we |-> 32'(waddr) < STORE_SIZE) else $error("write address out of store");
endmodule
`default_nettype wire

// ===== verif/mono_framebuffer_draw_engine_tb.sv =====
// self-checking testbench for the monochrome framebuffer draw engine
// drives requests with random idling and compares every response with a built-in predictor or a directed table value
// depends on mfde_pkg and the mono_framebuffer_draw_engine rtl
`timescale 1ns / 1ps
module mono_framebuffer_draw_engine_tb;
   import mfde_pkg::*;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  x;
      logic [7:0]  y;
      logic        color;
      logic [7:0]  char_code;
      logic [15:0] row_bits;
      logic [3:0]  row_index;
      logic [4:0]  glyph_width;
      logic        last_row;
      logic [7:0]  rect_width;
      logic [7:0]  rect_height;
   } draw_req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
   } draw_rsp_type;

   typedef struct {
      draw_req_type r;
      bit           typed;
      draw_rsp_type want;
   } table_row_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_REJ = 1'b1;
   localparam int   WATCHDOG   = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   draw_req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_status;
   logic [7:0] rsp_read_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [4:0] csr_font_height = FONT_HEIGHT_RESET;

   mono_framebuffer_draw_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_item.opcode), .req_x(req_item.x), .req_y(req_item.y),
      .req_color(req_item.color), .req_char_code(req_item.char_code),
      .req_row_bits(req_item.row_bits), .req_row_index(req_item.row_index),
      .req_glyph_width(req_item.glyph_width), .req_last_row(req_item.last_row),
      .req_rect_width(req_item.rect_width), .req_rect_height(req_item.rect_height),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_read_data(rsp_read_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_font_height(csr_font_height)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [7:0] shadow_frame [STORE_SIZE];
   logic [7:0] shadow_col, shadow_row;
   logic       shadow_skip;
   logic [4:0] shadow_font_height;

   draw_rsp_type expected_rsps [$];
   int mismatches = 0;
   int rsp_count = 0;
   int req_count = 0;
   int idle_cycles = 0;
   bit done_driving = 0;

   function automatic void shadow_pixel(int px, int py, logic white);
      int idx;
      if (px >= PANEL_WIDTH || py >= PANEL_HEIGHT) return;
      idx = px + (py / 8) * PANEL_WIDTH;
      if (white) shadow_frame[idx] |= 8'(1 << (py % 8));
      else shadow_frame[idx] &= ~8'(1 << (py % 8));
   endfunction

   function automatic draw_rsp_type predict_draw(draw_req_type r);
      draw_rsp_type o;
      logic on;
      o = '0;
      case (r.opcode)
         OP_CURSOR: begin
            shadow_col = r.x;
            shadow_row = r.y;
         end
         OP_FILL: begin
            foreach (shadow_frame[i]) shadow_frame[i] = r.color ? FILL_WHITE : FILL_BLACK;
         end
         OP_PIXEL: shadow_pixel(r.x, r.y, r.color);
         OP_GLYPH: begin
            if (r.row_index == 0)
               shadow_skip = (r.char_code < CHAR_MIN || r.char_code > CHAR_MAX ||
                  int'(shadow_col) + int'(r.glyph_width) > PANEL_WIDTH ||
                  int'(shadow_row) + int'(shadow_font_height) > PANEL_HEIGHT);
            if (shadow_skip) begin
               o.status = STATUS_REJ;
            end else begin
               if (r.row_index < shadow_font_height) begin
                  for (int j = 0; j < r.glyph_width; j++) begin
                     on = (j < 16) && (((r.row_bits << j) & GLYPH_MSB) != 0);
                     shadow_pixel(shadow_col + j, shadow_row + r.row_index,
                                  on ? r.color : ~r.color);
                  end
               end
               if (r.last_row) shadow_col = shadow_col + 8'(r.glyph_width);
            end
            if (r.last_row) shadow_skip = 0;
         end
         OP_RECT: begin
            if (int'(shadow_col) + r.rect_width > PANEL_WIDTH ||
                int'(shadow_row) + r.rect_height > PANEL_HEIGHT) begin
               o.status = STATUS_REJ;
            end else if (r.rect_width != 0 && r.rect_height != 0) begin
               for (int j = 0; j < r.rect_width; j++) begin
                  shadow_pixel(shadow_col + j, shadow_row, r.color);
                  shadow_pixel(shadow_col + j, shadow_row + r.rect_height - 1, r.color);
               end
               for (int j = 0; j < r.rect_height; j++) begin
                  shadow_pixel(shadow_col, shadow_row + j, r.color);
                  shadow_pixel(shadow_col + r.rect_width - 1, shadow_row + j, r.color);
               end
            end
         end
         OP_READ: begin
            if (r.x >= PANEL_WIDTH || r.y >= PAGE_COUNT) o.status = STATUS_REJ;
            else o.read_data = shadow_frame[r.x + r.y * PANEL_WIDTH];
         end
         default: o.status = STATUS_REJ;
      endcase
      return o;
   endfunction

   function automatic draw_req_type rand_fields();
      draw_req_type r;
      r = '0;
      r.x = 8'($urandom);
      r.y = 8'($urandom);
      r.color = 1'($urandom);
      r.char_code = 8'($urandom);
      r.row_bits = 16'($urandom);
      r.row_index = 4'($urandom);
      r.glyph_width = 5'($urandom_range(0, 16));
      r.last_row = 1'($urandom);
      r.rect_width = 8'($urandom);
      r.rect_height = 8'($urandom);
      return r;
   endfunction

   // valid stays up after an accept until the next request or an idle gap takes over
   task automatic send_draw(draw_req_type r, bit typed, draw_rsp_type want);
      draw_rsp_type p;
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      p = predict_draw(r);
      expected_rsps.push_back(typed ? want : p);
      req_item <= r;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_count++;
   endtask

   task automatic write_font_height(logic [4:0] h);
      req_valid <= 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_font_height <= h;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      shadow_font_height = h;
   endtask

   // a glyph of random content and size, rows well formed, random char code one time in ten, else printable
   task automatic send_glyph_run();
      draw_req_type r;
      int rows;
      logic [7:0] code;
      logic [4:0] gw;
      rows = $urandom_range(1, 16);
      code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
      gw = 5'($urandom_range(0, 16));
      for (int k = 0; k < rows; k++) begin
         r = rand_fields();
         r.opcode = OP_GLYPH;
         r.char_code = code;
         r.glyph_width = gw;
         r.row_index = 4'(k);
         r.last_row = (k == rows - 1);
         send_draw(r, 0, '0);
      end
   endtask

   // response side
   always @(posedge clock) begin
      draw_rsp_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response status=%0d data=%h",
                                               rsp_status, rsp_read_data);
            end else begin
               w = expected_rsps.pop_front();
               if (w.status !== rsp_status || w.read_data !== rsp_read_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch on response %0d: expected status=%0d data=%h, got status=%0d data=%h",
                              rsp_count, w.status, w.read_data, rsp_status, rsp_read_data);
               end
            end
         end
      end
   end

   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
               rsp_ready <= 0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1;
         end else if (!rsp_ready) begin
            rsp_ready <= 1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready) ||
          reset || (done_driving && expected_rsps.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("mono_framebuffer_draw_engine test failed");
         $finish;
      end
   end

   table_row_type directed [$];

   function automatic void add_row(logic [2:0] op, logic [7:0] x, logic [7:0] y, logic c,
                                   bit typed, logic st, logic [7:0] d);
      table_row_type t;
      t.r = '0;
      t.r.opcode = op; t.r.x = x; t.r.y = y; t.r.color = c;
      t.typed = typed; t.want.status = st; t.want.read_data = d;
      directed.push_back(t);
   endfunction

   function automatic void add_glyph(logic [7:0] code, logic [15:0] bits, logic [3:0] ri,
                                     logic [4:0] gw, logic last, logic c);
      table_row_type t;
      t.r = '0;
      t.r.opcode = OP_GLYPH; t.r.char_code = code; t.r.row_bits = bits;
      t.r.row_index = ri; t.r.glyph_width = gw; t.r.last_row = last; t.r.color = c;
      t.typed = 0; t.want = '0;
      directed.push_back(t);
   endfunction

   function automatic void add_rect(logic [7:0] w, logic [7:0] h, logic c);
      table_row_type t;
      t.r = '0;
      t.r.opcode = OP_RECT; t.r.rect_width = w; t.r.rect_height = h; t.r.color = c;
      t.typed = 0; t.want = '0;
      directed.push_back(t);
   endfunction

   initial begin
      draw_req_type r;
      int sel;
      foreach (shadow_frame[i]) shadow_frame[i] = FILL_BLACK;
      shadow_col = 0; shadow_row = 0; shadow_skip = 0;
      shadow_font_height = FONT_HEIGHT_RESET;

      add_row(OP_READ, 8'd0, 8'd0, 0, 1, STATUS_OK, 8'h00);
      add_row(OP_READ, 8'd127, 8'd7, 0, 1, STATUS_OK, 8'h00);
      add_row(OP_READ, 8'd128, 8'd0, 0, 1, STATUS_REJ, 8'h00);
      add_row(OP_READ, 8'd0, 8'd8, 0, 1, STATUS_REJ, 8'h00);
      add_row(3'd6, 8'hFF, 8'hFF, 1, 1, STATUS_REJ, 8'h00);
      add_row(3'd7, 8'h00, 8'h00, 0, 1, STATUS_REJ, 8'h00);
      add_row(OP_FILL, 8'd0, 8'd0, 1, 1, STATUS_OK, 8'h00);
      add_row(OP_READ, 8'd5, 8'd3, 0, 1, STATUS_OK, 8'hFF);
      add_row(OP_PIXEL, 8'd255, 8'd255, 0, 1, STATUS_OK, 8'h00);
      add_row(OP_PIXEL, 8'd127, 8'd63, 0, 1, STATUS_OK, 8'h00);
      add_row(OP_READ, 8'd127, 8'd7, 0, 1, STATUS_OK, 8'h7F);
      add_row(OP_FILL, 8'd0, 8'd0, 0, 1, STATUS_OK, 8'h00);
      add_row(OP_CURSOR, 8'd120, 8'd56, 0, 1, STATUS_OK, 8'h00);
      add_glyph(8'd31, 16'hFFFF, 4'd0, 5'd4, 0, 1);
      add_glyph(8'd65, 16'hFFFF, 4'd1, 5'd4, 1, 1);
      add_glyph(8'd126, 16'hA5A5, 4'd0, 5'd8, 0, 1);
      add_glyph(8'd126, 16'h8001, 4'd9, 5'd8, 1, 0);
      add_glyph(8'd32, 16'hFFFF, 4'd0, 5'd1, 1, 1);
      add_row(OP_CURSOR, 8'd0, 8'd0, 0, 1, STATUS_OK, 8'h00);
      add_glyph(8'd127, 16'h0000, 4'd0, 5'd16, 1, 1);
      add_glyph(8'd64, 16'hF00F, 4'd0, 5'd16, 1, 1);
      add_rect(8'd0, 8'd5, 1);
      add_rect(8'd113, 8'd64, 1);
      add_rect(8'd112, 8'd64, 1);
      add_rect(8'd1, 8'd1, 0);
      add_row(OP_READ, 8'd16, 8'd0, 0, 0, STATUS_OK, 8'h00);

      repeat (11) @(posedge clock);
      reset <= 0;

      foreach (directed[i]) send_draw(directed[i].r, directed[i].typed, directed[i].want);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_font_height(5'd1);
            1: write_font_height(5'd16);
            2: write_font_height(5'($urandom_range(2, 15)));
            default: write_font_height(FONT_HEIGHT_RESET);
         endcase
         while (req_count < 26 + (ph + 1) * 125) begin
            sel = $urandom_range(0, 99);
            r = rand_fields();
            if (sel < 40) begin
               if ($urandom_range(0, 1)) begin
                  r.opcode = OP_CURSOR;
                  r.x = 8'($urandom_range(0, 130));
                  r.y = 8'($urandom_range(0, 66));
                  send_draw(r, 0, '0);
               end
               send_glyph_run();
            end else begin
               if (sel < 48) r.opcode = OP_CURSOR;
               else if (sel < 50) r.opcode = OP_FILL;
               else if (sel < 62) r.opcode = OP_PIXEL;
               else if (sel < 67) r.opcode = OP_GLYPH;
               else if (sel < 77) begin
                  r.opcode = OP_RECT;
                  r.rect_width = 8'($urandom_range(0, 20));
                  r.rect_height = 8'($urandom_range(0, 20));
               end else if (sel < 97) begin
                  r.opcode = OP_READ;
                  r.x = 8'($urandom_range(0, 140));
                  r.y = 8'($urandom_range(0, 9));
               end else r.opcode = 3'($urandom_range(6, 7));
               if (sel < 48 && $urandom_range(0, 1)) begin
                  r.x = 8'($urandom_range(0, 127));
                  r.y = 8'($urandom_range(0, 63));
               end
               if (r.opcode == OP_PIXEL && $urandom_range(0, 3) != 0) begin
                  r.x = 8'($urandom_range(0, 127));
                  r.y = 8'($urandom_range(0, 63));
               end
               send_draw(r, 0, '0);
            end
         end
      end

      req_valid <= 0;
      done_driving = 1;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      $display("ran %0d requests over four font heights with random idling on both sides",
               req_count);
      $display("%0d responses checked, %0d mismatches", rsp_count, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("mono_framebuffer_draw_engine test passed");
      else
         $display("mono_framebuffer_draw_engine test failed");
      $finish;
   end
endmodule

// ===== mono_framebuffer_draw_engine.f =====
rtl/core/mfde_pkg.sv
rtl/core/mfde_ram.sv
rtl/core/mono_framebuffer_draw_engine.sv
verif/mono_framebuffer_draw_engine_tb.sv
